[rtl/core/itoa_pkg.sv]
package itoa_pkg;

  // Width of the number that is formatted; the input field itself is always 64 bits.
  localparam int VALUE_WIDTH = 64;
  localparam int IN_W        = 64;
  localparam int REQ_W       = 2;
  localparam int CHAR_W      = 8;

  // Hex64 always shows 16 digits, so the hex shifter is 64 bits whatever VALUE_WIDTH is.
  localparam int HEX_W       = 64;
  localparam int HEX32_DIGITS = 8;
  localparam int HEX64_DIGITS = HEX_W / 4;

  // Decimal digits needed for VALUE_WIDTH bits: floor(w * log10(2)) + 1
  localparam int DEC_DIGITS  = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int BCD_W       = 4 * DEC_DIGITS;
  localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_X     = 8'h78;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] ASCII_A_OFS = 8'h57;  // 'a' - 10

  typedef enum logic [REQ_W-1:0] {
    REQ_HEX32 = 2'd0,
    REQ_HEX64 = 2'd1,
    REQ_UDEC  = 2'd2,
    REQ_SDEC  = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    CH_ZERO  = 3'd0,
    CH_X     = 3'd1,
    CH_MINUS = 3'd2,
    CH_HEX   = 3'd3,
    CH_DEC   = 3'd4
  } char_sel_t;

  typedef struct packed {
    logic      load;
    logic      dabble;
    logic      dec_init;
    logic      shift_dec;
    logic      shift_hex;
    logic      emit;
    char_sel_t sel;
    logic      last;
  } itoa_cmd_t;

  typedef struct packed {
    logic neg;
    logic cnt_one;
    logic digit_zero;
    logic out_free;
  } itoa_stat_t;

  function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] d);
    logic [CHAR_W-1:0] r;
    if (d > 4'd9) begin
      r = {4'd0, d} + ASCII_A_OFS;
    end else begin
      r = {4'd0, d} + ASCII_ZERO;
    end
    return r;
  endfunction

  function automatic logic bcd_legal(input logic [BCD_W-1:0] b);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < DEC_DIGITS; i++) begin
      if (b[4*i +: 4] > 4'd9) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

endpackage

[rtl/core/itoa_if.sv]
interface itoa_in_if;
  logic                          valid;
  logic                          ready;
  logic [itoa_pkg::REQ_W-1:0]    req_type;
  logic [itoa_pkg::IN_W-1:0]     value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface itoa_out_if;
  logic                          valid;
  logic                          ready;
  logic [itoa_pkg::CHAR_W-1:0]   char_code;
  logic                          last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

[rtl/core/integer_to_ascii_formatter.sv]
// Channel  Dir  Fields                          Accepted when
// in_ch    in   req_type[1:0], value[63:0]      in_ch.valid && in_ch.ready
// out_ch   out  char_code[7:0], last_char       out_ch.valid && out_ch.ready
//
// One item at a time; in_ch.ready is high only between runs.
// Hex: a load, then "0x" and 8 (hex32) or 16 (hex64) digits, one character a cycle
// while out_ch does not stall. Decimal: a load, VALUE_WIDTH shift-and-add-3 steps, then
// DEC_DIGITS digit steps (leading zeros dropped without output), plus '-' if negative.
// Characters leave through a single output register; a stalled out_ch holds the sequencer.
// Synchronous reset clears the sequencer and the output valid; data registers are not reset.
module integer_to_ascii_formatter (
  input  logic       clk,
  input  logic       rst,
  itoa_in_if.sink    in_ch,
  itoa_out_if.source out_ch
);
  import itoa_pkg::*;

  itoa_cmd_t  cmd;
  itoa_stat_t st;
  req_t       req;

  assign req = req_t'(in_ch.req_type);

  itoa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_req   (req),
    .in_ready (in_ch.ready),
    .st       (st),
    .cmd      (cmd)
  );

  itoa_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_req   (req),
    .in_value (in_ch.value),
    .cmd      (cmd),
    .st       (st),
    .out_ch   (out_ch)
  );

endmodule

[rtl/core/itoa_ctrl.sv]
module itoa_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  itoa_pkg::req_t       in_req,
  output logic                 in_ready,
  input  itoa_pkg::itoa_stat_t st,
  output itoa_pkg::itoa_cmd_t  cmd
);
  import itoa_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DABBLE = 7'b0000010,
    S_SIGN   = 7'b0000100,
    S_PFX0   = 7'b0001000,
    S_PFXX   = 7'b0010000,
    S_HEX    = 7'b0100000,
    S_DEC    = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic   seen, seen_next;  // a decimal digit has gone out

  always_comb begin
    cmd        = '0;
    state_next = state;
    seen_next  = seen;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready  = 1'b1;
        seen_next = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_req == REQ_HEX32 || in_req == REQ_HEX64) begin
            state_next = S_PFX0;
          end else begin
            state_next = S_DABBLE;
          end
        end
      end
      S_DABBLE: begin
        cmd.dabble = 1'b1;
        if (st.cnt_one) begin
          cmd.dec_init = 1'b1;
          state_next   = st.neg ? S_SIGN : S_DEC;
        end
      end
      S_SIGN: begin
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          cmd.sel    = CH_MINUS;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        // leading zeros are dropped, but the units digit always goes out
        if (st.digit_zero && !seen && !st.cnt_one) begin
          cmd.shift_dec = 1'b1;
        end else if (st.out_free) begin
          cmd.emit      = 1'b1;
          cmd.sel       = CH_DEC;
          cmd.last      = st.cnt_one;
          cmd.shift_dec = 1'b1;
          seen_next     = 1'b1;
          if (st.cnt_one) begin
            state_next = S_IDLE;
          end
        end
      end
      S_PFX0: begin
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          cmd.sel    = CH_ZERO;
          state_next = S_PFXX;
        end
      end
      S_PFXX: begin
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          cmd.sel    = CH_X;
          state_next = S_HEX;
        end
      end
      S_HEX: begin
        if (st.out_free) begin
          cmd.emit      = 1'b1;
          cmd.sel       = CH_HEX;
          cmd.last      = st.cnt_one;
          cmd.shift_hex = 1'b1;
          if (st.cnt_one) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      seen  <= 1'b0;
    end else begin
      state <= state_next;
      seen  <= seen_next;
    end
  end

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> st.out_free)
    else $error("character loaded while output register occupied");

  a_dec_start: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && in_valid && (in_req == REQ_UDEC || in_req == REQ_SDEC))
      |=> state == S_DABBLE)
    else $error("decimal item did not start conversion");

  a_dabble_run: assert property (@(posedge clk) disable iff (rst)
    (state == S_DABBLE && !st.cnt_one) |=> state == S_DABBLE)
    else $error("conversion left early");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !cmd.emit)
    else $error("character emitted while idle");

endmodule

[rtl/core/itoa_dp.sv]
module itoa_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  itoa_pkg::req_t                in_req,
  input  logic [itoa_pkg::IN_W-1:0]     in_value,
  input  itoa_pkg::itoa_cmd_t           cmd,
  output itoa_pkg::itoa_stat_t          st,
  itoa_out_if.source                    out_ch
);
  import itoa_pkg::*;

  logic [HEX_W-1:0]       bin;
  logic [BCD_W-1:0]       bcd;
  logic [BCD_W-1:0]       bcd_adj;
  logic [CNT_W-1:0]       cnt;
  logic                   neg;
  logic [VALUE_WIDTH-1:0] v;
  logic [VALUE_WIDTH-1:0] mag;
  logic                   v_neg;
  logic [CHAR_W-1:0]      ch;
  logic                   out_valid;
  logic [CHAR_W-1:0]      char_code;
  logic                   last_char;

  assign v     = in_value[VALUE_WIDTH-1:0];
  assign v_neg = (in_req == REQ_SDEC) && v[VALUE_WIDTH-1];
  assign mag   = v_neg ? (~v + VALUE_WIDTH'(1)) : v;

  // add 3 to every digit of five or more ahead of the shift
  always_comb begin
    for (int i = 0; i < DEC_DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? (bcd[4*i +: 4] + 4'd3) : bcd[4*i +: 4];
    end
  end

  always_comb begin
    case (cmd.sel)
      CH_ZERO:  ch = ASCII_ZERO;
      CH_X:     ch = ASCII_X;
      CH_MINUS: ch = ASCII_MINUS;
      CH_HEX:   ch = hex_char(bin[HEX_W-1 -: 4]);
      CH_DEC:   ch = {4'd0, bcd[BCD_W-1 -: 4]} + ASCII_ZERO;
      default:  ch = ASCII_ZERO;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg <= v_neg;
      bcd <= '0;
      case (in_req)
        REQ_HEX32: begin
          bin <= {v[31:0], {(HEX_W-32){1'b0}}};
          cnt <= CNT_W'(HEX32_DIGITS);
        end
        REQ_HEX64: begin
          bin <= HEX_W'(v);
          cnt <= CNT_W'(HEX64_DIGITS);
        end
        default: begin
          bin <= HEX_W'(mag);
          cnt <= CNT_W'(VALUE_WIDTH);
        end
      endcase
    end else begin
      if (cmd.dabble) begin
        bcd <= {bcd_adj[BCD_W-2:0], bin[VALUE_WIDTH-1]};
        bin <= bin << 1;
      end else if (cmd.shift_dec) begin
        bcd <= bcd << 4;
      end else if (cmd.shift_hex) begin
        bin <= bin << 4;
      end
      if (cmd.dec_init) begin
        cnt <= CNT_W'(DEC_DIGITS);
      end else if (cmd.dabble || cmd.shift_dec || cmd.shift_hex) begin
        cnt <= cnt - CNT_W'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      char_code <= ch;
      last_char <= cmd.last;
    end
  end

  assign out_ch.valid     = out_valid;
  assign out_ch.char_code = char_code;
  assign out_ch.last_char = last_char;

  assign st.neg        = neg;
  assign st.cnt_one    = (cnt == CNT_W'(1));
  assign st.digit_zero = (bcd[BCD_W-1 -: 4] == 4'd0);
  assign st.out_free   = !out_valid || out_ch.ready;

  a_bcd_legal: assert property (@(posedge clk) disable iff (rst)
    cmd.shift_dec |-> bcd_legal(bcd))
    else $error("decimal digit out of range after conversion");

  a_emit_fills: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> out_valid)
    else $error("emitted character not held in output register");

endmodule

[dv/integer_to_ascii_formatter_tb.sv]
module integer_to_ascii_formatter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import itoa_pkg::*;

  localparam int RANDOM_REQS = 320;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 120;

  typedef struct {
    logic [CHAR_W-1:0] code;
    logic              last;
  } ascii_char_t;

  class ascii_scoreboard;
    ascii_char_t pending_chars[$];
    int errors;
    int requests;
    int chars_checked;

    task report(string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      errors++;
    endtask

    function logic [CHAR_W-1:0] nibble_char(logic [3:0] d);
      return (d > 4'd9) ? (8'h57 + CHAR_W'(d)) : (8'h30 + CHAR_W'(d));
    endfunction

    // Builds the full character run for one request and queues it.
    function void note_request(req_t req, logic [IN_W-1:0] value);
      logic [IN_W-1:0]   mask;
      logic [IN_W-1:0]   v;
      logic [CHAR_W-1:0] run[$];
      logic [CHAR_W-1:0] digits[$];
      int                n_hex;
      ascii_char_t       c;
      mask = (VALUE_WIDTH >= 64) ? '1 : ((64'd1 << VALUE_WIDTH) - 64'd1);
      v = value & mask;
      requests++;
      case (req)
        REQ_HEX32, REQ_HEX64: begin
          n_hex = (req == REQ_HEX32) ? 8 : 16;
          run.push_back(8'h30);
          run.push_back(8'h78);
          for (int k = n_hex - 1; k >= 0; k--) begin
            run.push_back(nibble_char(v[4*k +: 4]));
          end
        end
        default: begin
          if (req == REQ_SDEC && v[VALUE_WIDTH-1]) begin
            run.push_back(8'h2d);
            v = (~v + 64'd1) & mask;  // magnitude as unsigned, so the minimum prints
          end
          if (v == '0) begin
            digits.push_back(8'h30);
          end
          while (v != '0) begin
            digits.push_front(8'h30 + CHAR_W'(v % 64'd10));
            v = v / 64'd10;
          end
          foreach (digits[i]) run.push_back(digits[i]);
        end
      endcase
      foreach (run[i]) begin
        c.code = run[i];
        c.last = (i == run.size() - 1);
        pending_chars.push_back(c);
      end
    endfunction

    task check_char(logic [CHAR_W-1:0] code, logic last);
      ascii_char_t e;
      chars_checked++;
      if (pending_chars.size() == 0) begin
        report($sformatf("unexpected char %02h last=%0b", code, last));
      end else begin
        e = pending_chars.pop_front();
        if (code !== e.code) begin
          report($sformatf("char_code got %02h want %02h", code, e.code));
        end
        if (last !== e.last) begin
          report($sformatf("last_char got %0b want %0b (char %02h)", last, e.last, e.code));
        end
      end
    endtask
  endclass

  logic clk;
  logic rst;
  bit   quiet;
  int   cycles;

  ascii_scoreboard sb = new();

  itoa_in_if  in_ch ();
  itoa_out_if out_ch ();

  integer_to_ascii_formatter u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d chars outstanding", cycles,
               sb.pending_chars.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready) begin
      sb.note_request(req_t'(in_ch.req_type), in_ch.value);
    end
    if (!rst && out_ch.valid && out_ch.ready) begin
      sb.check_char(out_ch.char_code, out_ch.last_char);
    end
  end

  // Output back-pressure: ~9% stall, none while quiet.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready = quiet || ($urandom_range(99) >= 9);
    end
  end

  task send_request(req_t req, logic [IN_W-1:0] value);
    if (!quiet && $urandom_range(99) < 9) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_ch.valid    = 1'b1;
    in_ch.req_type = req;
    in_ch.value    = value;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  function logic [IN_W-1:0] random_value();
    logic [IN_W-1:0] v;
    case ($urandom_range(4))
      0: v = {$urandom, $urandom};
      1: v = IN_W'($urandom_range(1000));
      2: begin
        // around a power of ten, either sign
        v = 64'd1;
        repeat ($urandom_range(19)) v = v * 64'd10;
        v = v + IN_W'($urandom_range(2)) - 64'd1;
        if ($urandom_range(1)) v = ~v + 64'd1;
      end
      3: v = {$urandom, $urandom} >> $urandom_range(63);
      default: v = ~({$urandom, $urandom} >> $urandom_range(1, 63)) + 64'd1;
    endcase
    return v;
  endfunction

  initial begin
    rst            = 1'b1;
    quiet          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.req_type = REQ_HEX32;
    in_ch.value    = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: field extremes and the corner formats
    send_request(REQ_HEX32, 64'h0);
    send_request(REQ_HEX32, 64'hffff_ffff_ffff_ffff);
    send_request(REQ_HEX32, 64'hdead_beef_0123_abcd);
    send_request(REQ_HEX64, 64'h0);
    send_request(REQ_HEX64, 64'hffff_ffff_ffff_ffff);
    send_request(REQ_HEX64, 64'h0123_4567_89ab_cdef);
    send_request(REQ_UDEC,  64'd0);
    send_request(REQ_UDEC,  64'd1);
    send_request(REQ_UDEC,  64'd9);
    send_request(REQ_UDEC,  64'd10);
    send_request(REQ_UDEC,  64'd10000000000000000000);
    send_request(REQ_UDEC,  64'hffff_ffff_ffff_ffff);
    send_request(REQ_SDEC,  64'd0);
    send_request(REQ_SDEC,  64'd1);
    send_request(REQ_SDEC,  64'hffff_ffff_ffff_ffff);
    send_request(REQ_SDEC,  64'h8000_0000_0000_0000);
    send_request(REQ_SDEC,  64'h7fff_ffff_ffff_ffff);
    send_request(REQ_SDEC,  64'hffff_ffff_ffff_fff6);
    send_request(REQ_SDEC,  64'd12345);
    send_request(REQ_UDEC,  64'h8000_0000_0000_0000);

    for (int i = 0; i < RANDOM_REQS; i++) begin
      quiet = (i >= 100 && i < 180);
      send_request(req_t'($urandom_range(3)), random_value());
    end
    quiet       = 1'b0;
    in_ch.valid = 1'b0;

    while (sb.pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending_chars.size() != 0) begin
      sb.report($sformatf("%0d chars never arrived", sb.pending_chars.size()));
    end

    $display("Formatted %0d numbers in hex32/hex64/unsigned/signed, %0d chars checked",
             sb.requests, sb.chars_checked);
    $display("Random stalls on both channels, with a stall-free stretch mid-run");
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
